/* src/greedy_shift_reduce_recognizer_top_defines.svh */
// Assertion macros shared by the recognizer RTL.
`ifndef GREEDY_SHIFT_REDUCE_RECOGNIZER_TOP_DEFINES_SVH
`define GREEDY_SHIFT_REDUCE_RECOGNIZER_TOP_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define GSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define GSR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* src/gsr_pkg.sv */
// Package: constants, symbol codes and control types of the recognizer.
package gsr_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] SYM_I      = 8'h69;
    localparam logic [7:0] SYM_E      = 8'h45;
    localparam logic [7:0] SYM_LPAREN = 8'h28;
    localparam logic [7:0] SYM_RPAREN = 8'h29;
    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_STAR   = 8'h2A;
    localparam logic [7:0] SYM_SLASH  = 8'h2F;

    // Per-cell command: keep, take from the cell above, take from two below, load E
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_PUSH   = 2'd1,
        CELL_POP2   = 2'd2,
        CELL_LOAD_E = 2'd3
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REDUCE = 2'b10
    } state_t;

    function automatic logic is_operator(input logic [7:0] s);
        return (s == SYM_PLUS) || (s == SYM_MINUS) || (s == SYM_STAR) || (s == SYM_SLASH);
    endfunction

endpackage

/* src/gsr_if.sv */
// Request channel interfaces: input characters and recognizer results.
interface gsr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_of_string;

    modport source (output valid, output symbol, output last_of_string, input ready);
    modport sink   (input valid, input symbol, input last_of_string, output ready);
endinterface

interface gsr_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] reductions_made;
    logic [7:0] stack_depth;
    logic [7:0] top_symbol;
    logic       overflow;

    modport source (output valid, output accepted, output reductions_made,
                    output stack_depth, output top_symbol, output overflow,
                    input ready);
    modport sink   (input valid, input accepted, input reductions_made,
                    input stack_depth, input top_symbol, input overflow,
                    output ready);
endinterface

/* src/greedy_shift_reduce_recognizer_top.sv */
// Greedy shift-reduce expression recognizer: a row of stack cells with top-of-stack control.
//
// One request carries one character. The stack is a row of STACK_DEPTH cells, top
// in cell 0; a push shifts every cell down one place, and a three-symbol reduction
// shifts every cell up two places while the top cell loads E. The request is pushed
// in the cycle it is accepted, or dropped with overflow set if the stack is full;
// then one reduction is applied per cycle until none matches the three top cells,
// and the result is loaded into the output register once that register is free.
// The next character is accepted while a result still waits in the output register.
// The item marked last clears depth and overflow once its result is loaded.
`include "greedy_shift_reduce_recognizer_top_defines.svh"

module greedy_shift_reduce_recognizer_top (
    input  logic clk,
    input  logic rst_n,
    gsr_in_if.sink    req_ch,
    gsr_out_if.source res_ch
);

    localparam int N = gsr_pkg::STACK_DEPTH;
    localparam int W = gsr_pkg::DEPTH_W;

    gsr_pkg::state_t    state_reg, state_next;
    logic [W-1:0]       depth_reg, depth_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;
    logic [1:0]         count_reg, count_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_acc_reg, out_acc_next;
    logic [1:0]         out_red_reg, out_red_next;
    logic [7:0]         out_depth_reg, out_depth_next;
    logic [7:0]         out_top_reg, out_top_next;
    logic               out_ovf_reg, out_ovf_next;

    logic [7:0]         cell_val [N];
    gsr_pkg::cell_cmd_t top_cmd, rest_cmd;

    logic in_fire, full, rule_i, rule_3, rule_any, finish;

    assign req_ch.ready = (state_reg == gsr_pkg::ST_IDLE);
    assign in_fire      = req_ch.valid && req_ch.ready;
    assign full         = (depth_reg >= W'(N));

    // reduction rules seen on the three top cells
    always_comb
    begin
        rule_i = (depth_reg >= W'(1)) && (cell_val[0] == gsr_pkg::SYM_I);
        rule_3 = (depth_reg >= W'(3)) &&
                 (((cell_val[2] == gsr_pkg::SYM_LPAREN) && (cell_val[1] == gsr_pkg::SYM_E) &&
                   (cell_val[0] == gsr_pkg::SYM_RPAREN)) ||
                  ((cell_val[2] == gsr_pkg::SYM_E) && (cell_val[0] == gsr_pkg::SYM_E) &&
                   gsr_pkg::is_operator(cell_val[1])));
        rule_any = rule_i || rule_3;
    end

    assign finish = (state_reg == gsr_pkg::ST_REDUCE) && !rule_any &&
                    (!out_valid_reg || res_ch.ready);

    // cell commands
    always_comb
    begin
        top_cmd  = gsr_pkg::CELL_HOLD;
        rest_cmd = gsr_pkg::CELL_HOLD;
        if (in_fire && !full)
        begin
            top_cmd  = gsr_pkg::CELL_PUSH;
            rest_cmd = gsr_pkg::CELL_PUSH;
        end
        else if (state_reg == gsr_pkg::ST_REDUCE)
        begin
            if (rule_i)
            begin
                top_cmd = gsr_pkg::CELL_LOAD_E;
            end
            else if (rule_3)
            begin
                top_cmd  = gsr_pkg::CELL_LOAD_E;
                rest_cmd = gsr_pkg::CELL_POP2;
            end
        end
    end

    // row of cells
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        logic [7:0]         above, below;
        gsr_pkg::cell_cmd_t cmd;

        if (k == 0)
        begin : g_top
            assign above = req_ch.symbol;
            assign cmd   = top_cmd;
        end
        else
        begin : g_mid
            assign above = cell_val[k-1];
            assign cmd   = rest_cmd;
        end

        if (k + 2 < N)
        begin : g_low
            assign below = cell_val[k+2];
        end
        else
        begin : g_end
            assign below = cell_val[k];
        end

        gsr_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .value      (cell_val[k])
        );
    end

    // control and result
    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !res_ch.ready;
        out_acc_next   = out_acc_reg;
        out_red_next   = out_red_reg;
        out_depth_next = out_depth_reg;
        out_top_next   = out_top_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            gsr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next  = req_ch.last_of_string;
                    count_next = 2'd0;
                    if (full)
                        ovf_next = 1'b1;
                    else
                        depth_next = depth_reg + W'(1);
                    state_next = gsr_pkg::ST_REDUCE;
                end
            end
            gsr_pkg::ST_REDUCE:
            begin
                if (rule_any)
                begin
                    if (count_reg != 2'd3)
                        count_next = count_reg + 2'd1;
                    if (rule_3)
                        depth_next = depth_reg - W'(2);
                end
                else if (finish)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = (depth_reg == W'(1)) &&
                                     (cell_val[0] == gsr_pkg::SYM_E) && !ovf_reg;
                    out_red_next   = count_reg;
                    out_depth_next = 8'(depth_reg);
                    out_top_next   = (depth_reg == '0) ? 8'd0 : cell_val[0];
                    out_ovf_next   = ovf_reg;
                    if (last_reg)
                    begin
                        depth_next = '0;
                        ovf_next   = 1'b0;
                    end
                    state_next = gsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsr_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsr_pkg::ST_IDLE;
            depth_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        count_reg     <= count_next;
        out_acc_reg   <= out_acc_next;
        out_red_reg   <= out_red_next;
        out_depth_reg <= out_depth_next;
        out_top_reg   <= out_top_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign res_ch.valid           = out_valid_reg;
    assign res_ch.accepted        = out_acc_reg;
    assign res_ch.reductions_made = out_red_reg;
    assign res_ch.stack_depth     = out_depth_reg;
    assign res_ch.top_symbol      = out_top_reg;
    assign res_ch.overflow        = out_ovf_reg;

    // checks
    `GSR_NEVER(a_depth_bound, depth_reg > W'(N), "stack depth above capacity")
    `GSR_ASSERT(a_fire_reduce, in_fire |=> (state_reg == gsr_pkg::ST_REDUCE),
                "accepted request did not start reduction")
    `GSR_ASSERT(a_reduce_shrinks,
                ((state_reg == gsr_pkg::ST_REDUCE) && rule_any) |=> (depth_reg <= $past(depth_reg)),
                "reduction grew the stack")
    `GSR_ASSERT(a_accept_flags, (out_valid_reg && out_acc_reg) |-> (!out_ovf_reg &&
                (out_depth_reg == 8'd1) && (out_top_reg == gsr_pkg::SYM_E)),
                "accepted result inconsistent")

endmodule

/* src/gsr_cell.sv */
// One stack cell: holds one symbol, shifts down on push, up by two on reduce, or loads E.
module gsr_cell (
    input  logic              clk,
    input  gsr_pkg::cell_cmd_t cmd,
    input  logic [7:0]        from_above,
    input  logic [7:0]        from_below,
    output logic [7:0]        value
);

    logic [7:0] sym_reg;
    logic [7:0] sym_next;

    // next symbol by command
    always_comb
    begin
        case (cmd)
            gsr_pkg::CELL_HOLD:   sym_next = sym_reg;
            gsr_pkg::CELL_PUSH:   sym_next = from_above;
            gsr_pkg::CELL_POP2:   sym_next = from_below;
            gsr_pkg::CELL_LOAD_E: sym_next = gsr_pkg::SYM_E;
            default:              sym_next = sym_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    assign value = sym_reg;

endmodule

/* tb/greedy_shift_reduce_recognizer_top_test.sv */
// Testbench for the shift-reduce expression recognizer: directed and random strings checked by a scoreboard.
`timescale 1ns / 1ps

module greedy_shift_reduce_recognizer_top_test;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEM_TARGET  = 950;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 80;

    typedef struct packed {
        logic       accepted;
        logic [1:0] reductions;
        logic [7:0] depth;
        logic [7:0] top;
        logic       overflow;
    } verdict_t;

    typedef struct {
        logic [7:0] symbol;
        logic       last;
    } char_req_t;

    // Scoreboard: mirrors the symbol stack and queues the verdict of each character
    class recognizer_scoreboard;
        logic [7:0] cells [gsr_pkg::STACK_DEPTH];
        int         height;
        bit         overflowed;
        verdict_t   verdict_q [$];
        int         errors;

        function new();
            height     = 0;
            overflowed = 0;
            errors     = 0;
        endfunction

        function bit is_op(logic [7:0] s);
            case (s)
                gsr_pkg::SYM_PLUS, gsr_pkg::SYM_MINUS,
                gsr_pkg::SYM_STAR, gsr_pkg::SYM_SLASH: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // One rule at the top of the stack, in the order i, ( E ), E op E
        function bit reduce_top();
            if (height >= 1 && cells[height-1] == gsr_pkg::SYM_I)
            begin
                cells[height-1] = gsr_pkg::SYM_E;
                return 1'b1;
            end
            if (height >= 3 && cells[height-3] == gsr_pkg::SYM_LPAREN &&
                cells[height-2] == gsr_pkg::SYM_E && cells[height-1] == gsr_pkg::SYM_RPAREN)
            begin
                cells[height-3] = gsr_pkg::SYM_E;
                height          = height - 2;
                return 1'b1;
            end
            if (height >= 3 && cells[height-3] == gsr_pkg::SYM_E &&
                cells[height-1] == gsr_pkg::SYM_E && is_op(cells[height-2]))
            begin
                cells[height-3] = gsr_pkg::SYM_E;
                height          = height - 2;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(logic [7:0] sym, logic last);
            verdict_t v;
            int       steps;
            // push, or drop the symbol on a full stack
            if (height >= gsr_pkg::STACK_DEPTH)
                overflowed = 1'b1;
            else
            begin
                cells[height] = sym;
                height++;
            end
            steps = 0;
            while (reduce_top())
                if (steps < 3)
                    steps++;
            v.top        = (height > 0) ? cells[height-1] : 8'h00;
            v.depth      = 8'(height);
            v.accepted   = (height == 1 && v.top == gsr_pkg::SYM_E && !overflowed);
            v.reductions = 2'(steps);
            v.overflow   = overflowed;
            verdict_q.push_back(v);
            // end of string clears the stack for the next one
            if (last)
            begin
                height     = 0;
                overflowed = 1'b0;
            end
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            if (verdict_q.size() == 0)
            begin
                if (errors < 10)
                    $display({"%0t: result with no request outstanding: ",
                              "acc=%0d red=%0d depth=%0d top=%h ovf=%0d"},
                             $realtime, got.accepted, got.reductions, got.depth, got.top,
                             got.overflow);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            if (got.accepted !== want.accepted || got.reductions !== want.reductions ||
                got.depth !== want.depth || got.top !== want.top ||
                got.overflow !== want.overflow)
            begin
                if (errors < 10)
                    $display({"%0t: mismatch: expected acc=%0d red=%0d depth=%0d top=%h ",
                              "ovf=%0d, got acc=%0d red=%0d depth=%0d top=%h ovf=%0d"},
                             $realtime, want.accepted, want.reductions, want.depth, want.top,
                             want.overflow, got.accepted, got.reductions, got.depth, got.top,
                             got.overflow);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   taken  = 0;

    recognizer_scoreboard sb = new();
    char_req_t            stim [$];

    gsr_in_if  req_ch ();
    gsr_out_if res_ch ();

    greedy_shift_reduce_recognizer_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .res_ch (res_ch)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // No idling in the tail of the run
    function automatic bit calm();
        return taken + CALM_TAIL >= stim.size();
    endfunction

    function automatic logic [7:0] random_op();
        case ($urandom_range(0, 3))
            0: return gsr_pkg::SYM_PLUS;
            1: return gsr_pkg::SYM_MINUS;
            2: return gsr_pkg::SYM_STAR;
            default: return gsr_pkg::SYM_SLASH;
        endcase
    endfunction

    // Mostly grammar symbols, sometimes any nonzero byte
    function automatic logic [7:0] random_symbol();
        case ($urandom_range(0, 7))
            0: return gsr_pkg::SYM_I;
            1: return gsr_pkg::SYM_E;
            2: return gsr_pkg::SYM_LPAREN;
            3: return gsr_pkg::SYM_RPAREN;
            4, 5: return random_op();
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Well-formed expression of bounded nesting
    function automatic void add_expr(int lvl, ref logic [7:0] q [$]);
        int pick;
        pick = (lvl == 0) ? 0 : $urandom_range(0, 3);
        if (pick == 0)
            q.push_back(($urandom_range(0, 5) == 0) ? gsr_pkg::SYM_E : gsr_pkg::SYM_I);
        else if (pick == 1)
        begin
            q.push_back(gsr_pkg::SYM_LPAREN);
            add_expr(lvl - 1, q);
            q.push_back(gsr_pkg::SYM_RPAREN);
        end
        else
        begin
            add_expr(lvl - 1, q);
            q.push_back(random_op());
            add_expr(lvl - 1, q);
        end
    endfunction

    // Move a character string into the stimulus, marking its final character
    function automatic void add_string(ref logic [7:0] q [$]);
        char_req_t r;
        foreach (q[k])
        begin
            r.symbol = q[k];
            r.last   = (k == q.size() - 1);
            stim.push_back(r);
        end
        q.delete();
    endfunction

    function automatic void build_stimulus();
        logic [7:0] s [$];
        int         n_long;
        int         pick;
        int         n;
        // directed strings
        s = '{gsr_pkg::SYM_I};
        add_string(s);
        s = '{gsr_pkg::SYM_I, gsr_pkg::SYM_PLUS, gsr_pkg::SYM_I};
        add_string(s);
        s = '{gsr_pkg::SYM_LPAREN, gsr_pkg::SYM_I, gsr_pkg::SYM_RPAREN};
        add_string(s);
        s = '{gsr_pkg::SYM_I, gsr_pkg::SYM_MINUS, gsr_pkg::SYM_I, gsr_pkg::SYM_STAR,
              gsr_pkg::SYM_I, gsr_pkg::SYM_SLASH, gsr_pkg::SYM_I};
        add_string(s);
        s = '{gsr_pkg::SYM_E};
        add_string(s);
        s = '{gsr_pkg::SYM_I, gsr_pkg::SYM_PLUS};
        add_string(s);
        s = '{8'hFF, 8'h01};
        add_string(s);
        s = '{gsr_pkg::SYM_RPAREN};
        add_string(s);
        s = '{gsr_pkg::SYM_LPAREN, gsr_pkg::SYM_LPAREN, gsr_pkg::SYM_E,
              gsr_pkg::SYM_RPAREN, gsr_pkg::SYM_RPAREN};
        add_string(s);
        n_long = 0;
        while (stim.size() < ITEM_TARGET)
        begin
            if (n_long < 3 && stim.size() >= 250 * (n_long + 1))
            begin
                if (n_long == 0)
                begin
                    // open brackets and operators never reduce: fills the stack and overflows
                    repeat (130)
                        s.push_back(($urandom_range(0, 2) == 0) ? random_op()
                                                                : gsr_pkg::SYM_LPAREN);
                    s.push_back(gsr_pkg::SYM_I);
                    s.push_back(gsr_pkg::SYM_RPAREN);
                end
                else if (n_long == 1)
                begin
                    // deep nesting within capacity
                    n = $urandom_range(50, 63);
                    repeat (n) s.push_back(gsr_pkg::SYM_LPAREN);
                    s.push_back(gsr_pkg::SYM_I);
                    repeat (n) s.push_back(gsr_pkg::SYM_RPAREN);
                end
                else
                begin
                    // exactly full, then two closing brackets that are dropped
                    repeat (gsr_pkg::STACK_DEPTH - 1) s.push_back(gsr_pkg::SYM_LPAREN);
                    s.push_back(gsr_pkg::SYM_I);
                    s.push_back(gsr_pkg::SYM_RPAREN);
                    s.push_back(gsr_pkg::SYM_RPAREN);
                end
                add_string(s);
                n_long++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    add_expr($urandom_range(0, 4), s);
                else if (pick < 85)
                begin
                    // broken expression
                    add_expr($urandom_range(1, 4), s);
                    case ($urandom_range(0, 2))
                        0: if (s.size() > 1) void'(s.pop_back());
                        1: s[$urandom_range(0, s.size() - 1)] = random_symbol();
                        default: s.insert($urandom_range(0, s.size()), random_symbol());
                    endcase
                end
                else if (pick < 95)
                    repeat ($urandom_range(1, 8)) s.push_back(random_symbol());
                else
                    repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(1, 255)));
                add_string(s);
            end
        end
    endfunction

    // Offer every character, with random gaps
    task automatic drive_requests();
        foreach (stim[k])
        begin
            if (!calm() && $urandom_range(0, 4) == 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            req_ch.valid          <= 1'b1;
            req_ch.symbol         <= stim[k].symbol;
            req_ch.last_of_string <= stim[k].last;
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            sb.note_request(stim[k].symbol, stim[k].last);
            taken++;
            @(negedge clk);
        end
        req_ch.valid <= 1'b0;
    endtask

    // Result sink: random stalls and one long hold-off
    task automatic drain_results();
        bit held;
        int stall;
        held = 1'b0;
        forever
        begin
            if (!held && taken >= HOLD_AT)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (!calm() && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                stall = $urandom_range(1, 10);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                stall = $urandom_range(1, 12);
            end
            repeat (stall) @(negedge clk);
        end
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        verdict_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.accepted   = res_ch.accepted;
            got.reductions = res_ch.reductions_made;
            got.depth      = res_ch.stack_depth;
            got.top        = res_ch.top_symbol;
            got.overflow   = res_ch.overflow;
            sb.check_result(got);
        end
    end

    initial
    begin
        req_ch.valid          = 1'b0;
        req_ch.symbol         = 8'h00;
        req_ch.last_of_string = 1'b0;
        res_ch.ready          = 1'b0;
        build_stimulus();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        fork
            drain_results();
        join_none
        drive_requests();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
